// ===== hdl/pwltc_pkg.sv =====
// Shared types and constants for the piecewise linear tone curve.
// Holds level widths, register map codes and the divider cell beat.
// No dependencies.
package pwltc_pkg;

    localparam int LEVEL_W     = 8;
    localparam int NUM_W       = 2 * LEVEL_W + 1;
    localparam int PROD_W      = NUM_W + 1;
    localparam int POINT_SLOTS = 16;
    localparam int PT_PER_REG  = 4;
    localparam int PT_W        = 2 * LEVEL_W;
    localparam int REG_W       = 64;
    localparam int REG_NUM     = 4;
    localparam int CNT_W       = 5;
    localparam int ADDR_W      = 6;
    localparam int IDX_W       = 3;
    localparam int IDX_LSB     = 3;

    localparam logic [IDX_W-1:0] REG_POINTS_A    = 3'd0;
    localparam logic [IDX_W-1:0] REG_POINTS_B    = 3'd1;
    localparam logic [IDX_W-1:0] REG_POINTS_C    = 3'd2;
    localparam logic [IDX_W-1:0] REG_POINTS_D    = 3'd3;
    localparam logic [IDX_W-1:0] REG_POINT_COUNT = 3'd4;

    localparam logic [REG_W-1:0] POINTS_A_RESET    = 64'h0000_0000_FFFF_0000;
    localparam logic [CNT_W-1:0] POINT_COUNT_RESET = 5'd2;

    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [NUM_W-1:0]   quo;
        logic [LEVEL_W-1:0] rem;
        logic [LEVEL_W-1:0] den;
        logic               neg;
        logic [LEVEL_W-1:0] y0;
    } t_div_data;

endpackage

// ===== hdl/pwltc_div_cell.sv =====
// One cell of the restoring divider chain: one quotient bit per beat.
// Depends on pwltc_pkg for the t_div_data beat.
module pwltc_div_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  pwltc_pkg::t_div_data  i_data,
    output logic                  o_valid,
    output pwltc_pkg::t_div_data  o_data
);
    import pwltc_pkg::*;

    logic              r_valid;
    t_div_data         r_data;
    t_div_data         n_data;
    logic [LEVEL_W:0]  w_trial;
    logic [LEVEL_W:0]  w_diff;
    logic              w_ge;

    always_comb begin
        w_trial = {i_data.rem, i_data.num[NUM_W-1]};
        w_diff  = w_trial - {1'b0, i_data.den};
        w_ge    = (w_trial >= {1'b0, i_data.den});
        n_data      = i_data;
        n_data.num  = {i_data.num[NUM_W-2:0], 1'b0};
        n_data.quo  = {i_data.quo[NUM_W-2:0], w_ge};
        n_data.rem  = w_ge ? w_diff[LEVEL_W-1:0] : w_trial[LEVEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/piecewise_linear_tone_curve.sv =====
// Top level of the piecewise linear tone curve: config registers, segment
// select, slope product, divider cell chain and saturating output stage.
// Depends on pwltc_pkg and pwltc_div_cell.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------
//  input   | in        | i_valid / o_stall       | i_pixel_in
//  output  | out       | o_valid / i_stall       | o_pixel_out, o_clipped
//  config  | in        | psel/penable/pwrite/... | paddr, pwdata, prdata
//
// One beat enters per cycle unless the output stalls; beats pass stages 1-3,
// the 17-cell divider chain (one quotient bit per cell) and the output stage.
// Reset is synchronous, active low, and empties the pipeline.
// A stalled output beat freezes every stage; o_stall follows it.
module piecewise_linear_tone_curve #(
    parameter int MAX_POINTS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [pwltc_pkg::LEVEL_W-1:0]           i_pixel_in,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [pwltc_pkg::LEVEL_W-1:0]           o_pixel_out,
    output logic                                    o_clipped,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [pwltc_pkg::ADDR_W-1:0]            paddr,
    input  logic [pwltc_pkg::REG_W-1:0]             pwdata,
    output logic [pwltc_pkg::REG_W-1:0]             prdata,
    output logic                                    pready
);
    import pwltc_pkg::*;

    localparam int SEG_N = MAX_POINTS - 1;

    logic [REG_W-1:0]   r_points [REG_NUM];
    logic [CNT_W-1:0]   r_point_count;
    logic [IDX_W-1:0]   w_idx;
    logic [LEVEL_W-1:0] w_pt_x [POINT_SLOTS];
    logic [LEVEL_W-1:0] w_pt_y [POINT_SLOTS];
    logic               w_adv;

    logic [CNT_W-1:0]   w_cnt;
    logic [SEG_N-1:0]   w_hit;
    logic [SEG_N-1:0]   w_first;
    logic [SEG_N-1:0]   w_last;
    logic [SEG_N-1:0]   n_s1_sel;
    logic               n_s1_bypass;
    logic [LEVEL_W-1:0] n_s1_bval;
    logic               r_s1_valid;
    logic [SEG_N-1:0]   r_s1_sel;
    logic               r_s1_bypass;
    logic [LEVEL_W-1:0] r_s1_bval;
    logic [LEVEL_W-1:0] r_s1_x;

    logic [LEVEL_W-1:0]        w_x0, w_y0, w_x1, w_y1;
    logic signed [LEVEL_W:0]   n_s2_dx, n_s2_dxn, n_s2_dy;
    logic                      n_s2_zero;
    logic [LEVEL_W-1:0]        n_s2_y0;
    logic                      r_s2_valid;
    logic signed [LEVEL_W:0]   r_s2_dx, r_s2_dxn, r_s2_dy;
    logic                      r_s2_zero;
    logic [LEVEL_W-1:0]        r_s2_y0;

    logic signed [PROD_W-1:0]  w_prod;
    logic [PROD_W-1:0]         w_prod_mag;
    logic [LEVEL_W:0]          w_den_mag;
    t_div_data                 n_s3_data;
    logic                      r_s3_valid;
    t_div_data                 r_s3_data;

    logic                      w_cell_valid [NUM_W+1];
    t_div_data                 w_cell_data  [NUM_W+1];

    t_div_data                 w_last_data;
    logic signed [PROD_W-1:0]  w_q;
    logic signed [PROD_W-1:0]  w_sum;
    logic [LEVEL_W-1:0]        n_out_pixel;
    logic                      n_out_clip;
    logic                      r_out_valid;
    logic [LEVEL_W-1:0]        r_out_pixel;
    logic                      r_out_clip;

    // configuration port
    assign w_idx  = paddr[IDX_LSB +: IDX_W];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points[0]   <= POINTS_A_RESET;
            r_points[1]   <= '0;
            r_points[2]   <= '0;
            r_points[3]   <= '0;
            r_point_count <= POINT_COUNT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx) inside
                [REG_POINTS_A:REG_POINTS_D]: begin
                    r_points[w_idx[1:0]] <= pwdata;
                end
                REG_POINT_COUNT: begin
                    r_point_count <= pwdata[CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx) inside
            [REG_POINTS_A:REG_POINTS_D]: prdata = r_points[w_idx[1:0]];
            REG_POINT_COUNT:             prdata = {{(REG_W-CNT_W){1'b0}}, r_point_count};
            default:                     prdata = '0;
        endcase
    end

    always_comb begin
        for (int k = 0; k < POINT_SLOTS; k++) begin
            w_pt_x[k] = r_points[k / PT_PER_REG][(k % PT_PER_REG) * PT_W +: LEVEL_W];
            w_pt_y[k] = r_points[k / PT_PER_REG][(k % PT_PER_REG) * PT_W + LEVEL_W +: LEVEL_W];
        end
    end

    // pipeline control
    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    // stage 1: segment search
    always_comb begin
        w_cnt = (r_point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : r_point_count;
        for (int k = 0; k < SEG_N; k++) begin
            w_hit[k]  = (CNT_W'(k + 2) <= w_cnt) && (i_pixel_in >= w_pt_x[k])
                        && (i_pixel_in <= w_pt_x[k + 1]);
            w_last[k] = (w_cnt == CNT_W'(k + 2));
        end
        w_first     = w_hit & (~w_hit + SEG_N'(1));
        n_s1_sel    = (|w_hit) ? w_first : w_last;
        n_s1_bypass = (w_cnt < CNT_W'(2));
        n_s1_bval   = (w_cnt == '0) ? i_pixel_in : w_pt_y[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_sel    <= n_s1_sel;
            r_s1_bypass <= n_s1_bypass;
            r_s1_bval   <= n_s1_bval;
            r_s1_x      <= i_pixel_in;
        end
    end

    // stage 2: fetch segment end points, form differences
    always_comb begin
        w_x0 = '0;
        w_y0 = '0;
        w_x1 = '0;
        w_y1 = '0;
        for (int k = 0; k < SEG_N; k++) begin
            if (r_s1_sel[k]) begin
                w_x0 = w_x0 | w_pt_x[k];
                w_y0 = w_y0 | w_pt_y[k];
                w_x1 = w_x1 | w_pt_x[k + 1];
                w_y1 = w_y1 | w_pt_y[k + 1];
            end
        end
        n_s2_dx   = $signed({1'b0, w_x1}) - $signed({1'b0, w_x0});
        n_s2_dxn  = $signed({1'b0, r_s1_x}) - $signed({1'b0, w_x0});
        n_s2_dy   = $signed({1'b0, w_y1}) - $signed({1'b0, w_y0});
        n_s2_zero = r_s1_bypass || (n_s2_dx == '0);
        n_s2_y0   = r_s1_bypass ? r_s1_bval : w_y0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_dx   <= n_s2_dx;
            r_s2_dxn  <= n_s2_dxn;
            r_s2_dy   <= n_s2_dy;
            r_s2_zero <= n_s2_zero;
            r_s2_y0   <= n_s2_y0;
        end
    end

    // stage 3: slope product and divider operands
    always_comb begin
        w_prod     = PROD_W'(r_s2_dxn * r_s2_dy);
        w_prod_mag = w_prod[PROD_W-1] ? PROD_W'(-w_prod) : PROD_W'(w_prod);
        w_den_mag  = r_s2_dx[LEVEL_W] ? (LEVEL_W+1)'(-r_s2_dx) : (LEVEL_W+1)'(r_s2_dx);
        n_s3_data.quo = '0;
        n_s3_data.rem = '0;
        n_s3_data.y0  = r_s2_y0;
        if (r_s2_zero) begin
            n_s3_data.num = '0;
            n_s3_data.den = LEVEL_W'(1);
            n_s3_data.neg = 1'b0;
        end else begin
            n_s3_data.num = w_prod_mag[NUM_W-1:0];
            n_s3_data.den = w_den_mag[LEVEL_W-1:0];
            n_s3_data.neg = w_prod[PROD_W-1] ^ r_s2_dx[LEVEL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_data <= n_s3_data;
        end
    end

    // divider cell chain
    assign w_cell_valid[0] = r_s3_valid;
    assign w_cell_data[0]  = r_s3_data;

    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        pwltc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_cell_valid[g]),
            .i_data  (w_cell_data[g]),
            .o_valid (w_cell_valid[g + 1]),
            .o_data  (w_cell_data[g + 1])
        );
    end

    // output stage: sign, offset, saturate
    always_comb begin
        w_last_data = w_cell_data[NUM_W];
        w_q   = w_last_data.neg ? -$signed({1'b0, w_last_data.quo})
                                :  $signed({1'b0, w_last_data.quo});
        w_sum = $signed({{(PROD_W-LEVEL_W){1'b0}}, w_last_data.y0}) + w_q;
        if (w_sum[PROD_W-1]) begin
            n_out_pixel = '0;
            n_out_clip  = 1'b1;
        end else if (|w_sum[PROD_W-2:LEVEL_W]) begin
            n_out_pixel = '1;
            n_out_clip  = 1'b1;
        end else begin
            n_out_pixel = w_sum[LEVEL_W-1:0];
            n_out_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_cell_valid[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pixel <= n_out_pixel;
            r_out_clip  <= n_out_clip;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pixel;
    assign o_clipped   = r_out_clip;

    // checks
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_s1_bypass |-> $onehot(r_s1_sel))
        else $error("segment select not one-hot");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> (r_s3_data.den != '0))
        else $error("divider fed a zero divisor");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell_valid[NUM_W] |-> (w_cell_data[NUM_W].rem < w_cell_data[NUM_W].den))
        else $error("divider remainder out of range");

    a_clip_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |-> (o_pixel_out == '0 || o_pixel_out == '1))
        else $error("clipped beat not at a rail");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for piecewise_linear_tone_curve: a directed table of pixels and curves,
// then random curves and pixels checked against an in-bench tone curve predictor.
// Depends on pwltc_pkg and piecewise_linear_tone_curve.
module tb;
    import pwltc_pkg::*;

    localparam int MAX_KNOTS      = POINT_SLOTS;
    localparam int LEVEL_MAX      = (1 << LEVEL_W) - 1;
    localparam int CNT_MAX        = (1 << CNT_W) - 1;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 40;
    localparam int HOLD_OFF_CYC   = 200;
    localparam int DRAIN_CYC      = 30;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic [REG_NUM-1:0][REG_W-1:0] t_curve_regs;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               clipped;
    } t_tone;

    typedef struct {
        bit                 load;
        t_curve_regs        pts;
        logic [CNT_W-1:0]   cnt;
        logic [LEVEL_W-1:0] px;
        bit                 typed;
        t_tone              want;
    } t_dir_row;

    typedef enum {CURVE_SORTED, CURVE_NOISE, CURVE_FEW, CURVE_OVER} t_curve_kind;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic [LEVEL_W-1:0] i_pixel_in  = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic [LEVEL_W-1:0] o_pixel_out;
    logic               o_clipped;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [ADDR_W-1:0]  paddr       = '0;
    logic [REG_W-1:0]   pwdata      = '0;
    logic [REG_W-1:0]   prdata;
    logic               pready;

    t_curve_regs        curve_pts = t_curve_regs'(POINTS_A_RESET);
    logic [CNT_W-1:0]   curve_cnt = POINT_COUNT_RESET;
    t_curve_regs        cand_pts;
    logic [CNT_W-1:0]   cand_cnt;

    t_tone              tone_q[$];
    t_tone              want_out;
    t_dir_row           dir_rows[$];
    int                 err_cnt       = 0;
    int                 idle_cycles   = 0;
    int                 hold_off_reqs = 0;
    bit                 holding       = 1'b0;
    bit                 tx_quiet      = 1'b0;
    bit                 rx_quiet      = 1'b0;

    piecewise_linear_tone_curve #(
        .MAX_POINTS(MAX_KNOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pixel_in (i_pixel_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pixel_out(o_pixel_out),
        .o_clipped  (o_clipped),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int knot_x(input int k);
        return int'(curve_pts[k / PT_PER_REG][(k % PT_PER_REG) * PT_W +: LEVEL_W]);
    endfunction

    function automatic int knot_y(input int k);
        return int'(curve_pts[k / PT_PER_REG][(k % PT_PER_REG) * PT_W + LEVEL_W +: LEVEL_W]);
    endfunction

    function automatic t_tone tone_map(input logic [LEVEL_W-1:0] px);
        int    n, seg, k, x0, y0, x1, y1, dx, r;
        t_tone res;
        n = (curve_cnt > MAX_KNOTS) ? MAX_KNOTS : int'(curve_cnt);
        res.clipped = 1'b0;
        if (n == 0) begin
            res.level = px;
        end else if (n == 1) begin
            res.level = LEVEL_W'(knot_y(0));
        end else begin
            seg = n - 2;
            for (k = n - 2; k >= 0; k--) begin
                if (int'(px) >= knot_x(k) && int'(px) <= knot_x(k + 1)) seg = k;
            end
            x0 = knot_x(seg);
            y0 = knot_y(seg);
            x1 = knot_x(seg + 1);
            y1 = knot_y(seg + 1);
            dx = x1 - x0;
            r  = (dx == 0) ? y0 : y0 + (int'(px) - x0) * (y1 - y0) / dx;
            if (r < 0) begin
                res.level   = '0;
                res.clipped = 1'b1;
            end else if (r > LEVEL_MAX) begin
                res.level   = '1;
                res.clipped = 1'b1;
            end else begin
                res.level = LEVEL_W'(r);
            end
        end
        return res;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void add_row(input bit load, input t_curve_regs pts,
                                    input logic [CNT_W-1:0] cnt, input logic [LEVEL_W-1:0] px,
                                    input bit typed, input logic [LEVEL_W-1:0] lvl,
                                    input logic clip);
        t_dir_row row;
        row.load  = load;
        row.pts   = pts;
        row.cnt   = cnt;
        row.px    = px;
        row.typed = typed;
        row.want  = '{lvl, clip};
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    task automatic send_pixel(input logic [LEVEL_W-1:0] px, input t_tone want);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tone_q.insert(tone_q.size(), want);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (tone_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, {IDX_LSB{1'b0}}});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx < REG_NUM) curve_pts[idx] = data;
        else if (idx == REG_POINT_COUNT) curve_cnt = data[CNT_W-1:0];
    endtask

    task automatic load_curve();
        wait_drained();
        reg_write(REG_POINTS_A, cand_pts[0]);
        reg_write(REG_POINTS_B, cand_pts[1]);
        reg_write(REG_POINTS_C, cand_pts[2]);
        reg_write(REG_POINTS_D, cand_pts[3]);
        reg_write(REG_POINT_COUNT, REG_W'(cand_cnt));
        // stray index above the map, must be dropped
        if ($urandom_range(0, 1)) begin
            reg_write(IDX_W'($urandom_range(int'(REG_POINT_COUNT) + 1, (1 << IDX_W) - 1)),
                      {$urandom, $urandom});
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic build_curve(input t_curve_kind kind);
        int n, x, k;
        n = (kind == CURVE_SORTED) ? $urandom_range(2, MAX_KNOTS) : MAX_KNOTS;
        x = $urandom_range(0, 24);
        for (k = 0; k < MAX_KNOTS; k++) begin
            cand_pts[k / PT_PER_REG][(k % PT_PER_REG) * PT_W +: PT_W] =
                {LEVEL_W'($urandom), LEVEL_W'(x)};
            x = x + $urandom_range(0, 512 / n);
            if (x > LEVEL_MAX) x = LEVEL_MAX;
        end
        case (kind)
            CURVE_NOISE: begin
                for (k = 0; k < REG_NUM; k++) cand_pts[k] = {$urandom, $urandom};
                cand_cnt = CNT_W'($urandom_range(0, CNT_MAX));
            end
            CURVE_FEW:  cand_cnt = CNT_W'($urandom_range(0, 1));
            CURVE_OVER: cand_cnt = CNT_W'($urandom_range(MAX_KNOTS, CNT_MAX));
            default:    cand_cnt = CNT_W'(n);
        endcase
    endtask

    initial begin : rx_stall_gen
        int dur;
        int seen;
        bit busy;
        seen = 0;
        @(posedge i_clk);
        forever begin
            if (hold_off_reqs != seen) begin
                seen    = hold_off_reqs;
                busy    = 1'b1;
                dur     = HOLD_OFF_CYC;
                holding = 1'b1;
            end else if (rx_quiet) begin
                busy    = 1'b0;
                dur     = 1;
                holding = 1'b0;
            end else begin
                busy    = ($urandom_range(0, 3) == 0);
                dur     = busy ? pick_gap(1'b0) + 1 : $urandom_range(1, 12);
                holding = 1'b0;
            end
            i_stall <= busy;
            repeat (dur) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (tone_q.size() == 0) begin
                $error("output beat with no expectation: pixel_out %0d clipped %0d",
                       o_pixel_out, o_clipped);
                err_cnt++;
            end else begin
                want_out = tone_q.pop_front();
                if (o_pixel_out !== want_out.level) begin
                    $error("pixel_out: expected %0d, got %0d", want_out.level, o_pixel_out);
                    err_cnt++;
                end
                if (o_clipped !== want_out.clipped) begin
                    $error("clipped: expected %0d, got %0d", want_out.clipped, o_clipped);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_curve_regs        over_pts;
        t_curve_kind        kind;
        logic [LEVEL_W-1:0] px;
        int                 ph, j, pick;

        over_pts = {64'hFFF0_00E0_80D0_10C0, 64'hC0B0_20A0_E090_4080,
                    64'h9070_6060_3050_5040, 64'h4030_2020_1010_0000};

        // reset curve is the identity line
        add_row(1'b0, '0, '0, 8'h00, 1'b1, 8'h00, 1'b0);
        add_row(1'b0, '0, '0, 8'hFF, 1'b1, 8'hFF, 1'b0);
        add_row(1'b0, '0, '0, 8'h55, 1'b1, 8'h55, 1'b0);
        add_row(1'b0, '0, '0, 8'hAA, 1'b1, 8'hAA, 1'b0);
        // no points: pass through
        add_row(1'b1, '0, 5'd0, 8'h37, 1'b1, 8'h37, 1'b0);
        add_row(1'b0, '0, '0, 8'hC8, 1'b1, 8'hC8, 1'b0);
        // one point: constant y
        add_row(1'b1, {192'd0, 64'h9A40}, 5'd1, 8'h00, 1'b1, 8'h9A, 1'b0);
        add_row(1'b0, '0, '0, 8'hFF, 1'b1, 8'h9A, 1'b0);
        // zero-width segment
        add_row(1'b1, {192'd0, 64'hC864_2864}, 5'd2, 8'd100, 1'b1, 8'd40, 1'b0);
        add_row(1'b0, '0, '0, 8'd50, 1'b1, 8'd40, 1'b0);
        // saturate high, then low
        add_row(1'b1, {192'd0, 64'hC80A_0000}, 5'd2, 8'hFF, 1'b1, 8'hFF, 1'b1);
        add_row(1'b0, '0, '0, 8'd5, 1'b1, 8'd100, 1'b0);
        add_row(1'b1, {192'd0, 64'h000A_FF00}, 5'd2, 8'hFF, 1'b1, 8'h00, 1'b1);
        // unsorted points, negative width, truncation toward zero
        add_row(1'b1, {192'd0, 64'h0000_FB1E_5A32_0AC8}, 5'd3, 8'd0, 1'b0, '0, 1'b0);
        add_row(1'b0, '0, '0, 8'd49, 1'b0, '0, 1'b0);
        add_row(1'b0, '0, '0, 8'd60, 1'b0, '0, 1'b0);
        add_row(1'b0, '0, '0, 8'd200, 1'b0, '0, 1'b0);
        // count above the point limit
        add_row(1'b1, over_pts, 5'd31, 8'hFF, 1'b0, '0, 1'b0);
        add_row(1'b0, '0, '0, 8'hC8, 1'b0, '0, 1'b0);
        add_row(1'b0, '0, '0, 8'h00, 1'b0, '0, 1'b0);
        add_row(1'b1, over_pts, 5'd17, 8'h9C, 1'b0, '0, 1'b0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].load) begin
                cand_pts = dir_rows[i].pts;
                cand_cnt = dir_rows[i].cnt;
                load_curve();
            end
            send_pixel(dir_rows[i].px,
                       dir_rows[i].typed ? dir_rows[i].want : tone_map(dir_rows[i].px));
        end

        for (ph = 0; ph < PHASES; ph++) begin
            pick = $urandom_range(0, 9);
            if (ph == 0) kind = CURVE_OVER;
            else if (ph == 1) kind = CURVE_NOISE;
            else if (ph == 2) kind = CURVE_FEW;
            else if (pick < 6) kind = CURVE_SORTED;
            else if (pick < 8) kind = CURVE_NOISE;
            else if (pick == 8) kind = CURVE_FEW;
            else kind = CURVE_OVER;
            build_curve(kind);
            load_curve();
            tx_quiet = (ph == 3 || ph == 5);
            rx_quiet = (ph == 5);
            // hold the receiver and keep offering beats until the input stalls
            if (ph == 3) begin
                hold_off_reqs++;
                while (!holding) @(posedge i_clk);
            end
            for (j = 0; j < PHASE_ITEMS; j++) begin
                case ($urandom_range(0, 9))
                    0:       px = $urandom_range(0, 1) ? '1 : '0;
                    1, 2, 3: px = LEVEL_W'(knot_x($urandom_range(0, MAX_KNOTS - 1)) +
                                           $urandom_range(0, 2) - 1);
                    default: px = LEVEL_W'($urandom);
                endcase
                send_pixel(px, tone_map(px));
            end
        end

        tx_quiet = 1'b0;
        rx_quiet = 1'b1;
        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
